// ----- rtl/core/gtht_pkg.sv -----
// ----------------------------------------------------------------------------
// gtht_pkg
// Shared types, constants and helpers for the generation-tagged handle table.
// ----------------------------------------------------------------------------
package gtht_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned BIT_AW     = $clog2(ROW_W);
  localparam int unsigned ROWS       = SLOT_COUNT / ROW_W;
  localparam int unsigned ROW_AW     = IDX_W - BIT_AW;
  localparam int unsigned GEN_W      = 32;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned HANDLE_W   = 64;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_FREE    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_EXHAUSTED    = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_FREE    = 2'd2,
    OP_REPLY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_PICK   = 2'd1,
    S_COMMIT = 2'd2
  } state_t;

  typedef struct packed {
    op_t               op;
    status_t           reply;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t head;
  } queue_head_t;

  // lowest clear bit of an occupancy row
  function automatic logic [BIT_AW-1:0] lowest_zero_bit(input logic [ROW_W-1:0] v);
    logic [BIT_AW-1:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!v[i]) r = BIT_AW'(i);
    end
    return r;
  endfunction

  // lowest row not marked full
  function automatic logic [ROW_AW-1:0] lowest_zero_row(input logic [ROWS-1:0] v);
    logic [ROW_AW-1:0] r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!v[i]) r = ROW_AW'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/gtht_front.sv -----
// ----------------------------------------------------------------------------
// gtht_front
// Accepts commands, checks handles and queues classified items for the
// execution side in a two-entry queue.
// ----------------------------------------------------------------------------
module gtht_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [gtht_pkg::HANDLE_W-1:0]     handle,
  input  logic [gtht_pkg::VAL_W-1:0]        entry_value,
  input  logic                              pop,
  output gtht_pkg::queue_head_t             q_out
);

  gtht_pkg::cmd_t cmd_in;
  gtht_pkg::cmd_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           idx_ok;

  assign idx_ok = (handle != '0) && (handle[31:0] < 32'(gtht_pkg::SLOT_COUNT));

  always_comb begin
    cmd_in.op    = gtht_pkg::OP_REPLY;
    cmd_in.reply = gtht_pkg::ST_NOT_FOUND;
    cmd_in.idx   = handle[gtht_pkg::IDX_W-1:0];
    cmd_in.gen   = handle[63:32];
    cmd_in.value = entry_value;
    unique case (action)
      gtht_pkg::ACT_ALLOC: begin
        cmd_in.op = gtht_pkg::OP_ALLOC;
      end
      gtht_pkg::ACT_RESOLVE: begin
        if (idx_ok) cmd_in.op = gtht_pkg::OP_RESOLVE;
      end
      gtht_pkg::ACT_FREE: begin
        if (idx_ok) begin
          cmd_in.op = gtht_pkg::OP_FREE;
        end else begin
          cmd_in.reply = gtht_pkg::ST_FREE_IGNORED;
        end
      end
      default: begin
        cmd_in.op = gtht_pkg::OP_REPLY;
      end
    endcase
  end

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  assign q_out.valid = (count != 2'd0);
  assign q_out.head  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/gtht_back.sv -----
// ----------------------------------------------------------------------------
// gtht_back
// Executes queued items against the slot table: occupancy rows with row-full
// summary, generation and value memories, and a high-water mark.
// ----------------------------------------------------------------------------
module gtht_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gtht_pkg::queue_head_t             q_in,
  output logic                              pop,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [gtht_pkg::HANDLE_W-1:0]     handle_out,
  output logic [gtht_pkg::VAL_W-1:0]        entry_out
);

  localparam int unsigned IDX_W  = gtht_pkg::IDX_W;
  localparam int unsigned CNT_W  = gtht_pkg::CNT_W;
  localparam int unsigned ROW_W  = gtht_pkg::ROW_W;
  localparam int unsigned BIT_AW = gtht_pkg::BIT_AW;
  localparam int unsigned ROW_AW = gtht_pkg::ROW_AW;
  localparam int unsigned GEN_W  = gtht_pkg::GEN_W;
  localparam int unsigned VAL_W  = gtht_pkg::VAL_W;

  gtht_pkg::state_t state;
  gtht_pkg::state_t state_next;

  // memories
  logic [ROW_W-1:0] occ_mem [gtht_pkg::ROWS];
  logic [GEN_W-1:0] gen_mem [gtht_pkg::SLOT_COUNT];
  logic [VAL_W-1:0] val_mem [gtht_pkg::SLOT_COUNT];

  logic [ROW_W-1:0] occ_q;
  logic [GEN_W-1:0] gen_q;
  logic [VAL_W-1:0] val_q;

  logic [gtht_pkg::ROWS-1:0] row_full;
  logic [CNT_W-1:0]          hwm;

  gtht_pkg::cmd_t    cmd;
  logic [ROW_AW-1:0] row;
  logic [IDX_W-1:0]  alloc_idx;
  logic [ROW_W-1:0]  occ_new;

  // combinational control
  logic              all_full;
  logic [ROW_AW-1:0] sel_row;
  logic [ROW_AW-1:0] occ_raddr;
  logic [IDX_W-1:0]  gen_raddr;
  logic              gen_re;
  logic [ROW_W-1:0]  row_mask;
  logic [ROW_W-1:0]  occ_masked;
  logic [BIT_AW-1:0] free_bit;
  logic [IDX_W-1:0]  alloc_idx_next;
  logic [ROW_W-1:0]  occ_new_next;
  logic              occ_we;
  logic [ROW_W-1:0]  occ_wdata;
  logic              commit;
  logic              free_we;
  logic [GEN_W-1:0]  gen_cur;
  logic [GEN_W-1:0]  gen_new;
  logic              res_fire;
  gtht_pkg::status_t res_status;
  logic [gtht_pkg::HANDLE_W-1:0] res_handle;
  logic [VAL_W-1:0]  res_entry;

  assign all_full = &row_full;
  assign sel_row  = (q_in.head.op == gtht_pkg::OP_ALLOC) ?
                    gtht_pkg::lowest_zero_row(row_full) :
                    q_in.head.idx[IDX_W-1:BIT_AW];

  // slots at or above the high-water mark were never allocated
  always_comb begin
    if ({1'b0, row} < hwm[CNT_W-1:BIT_AW]) begin
      row_mask = '1;
    end else if ({1'b0, row} == hwm[CNT_W-1:BIT_AW]) begin
      row_mask = (ROW_W'(1) << hwm[BIT_AW-1:0]) - ROW_W'(1);
    end else begin
      row_mask = '0;
    end
  end

  assign occ_masked     = occ_q & row_mask;
  assign free_bit       = gtht_pkg::lowest_zero_bit(occ_masked);
  assign alloc_idx_next = {row, free_bit};
  assign occ_new_next   = occ_masked | (ROW_W'(1) << free_bit);

  always_comb begin
    gen_cur = gen_q;
    if (state == gtht_pkg::S_COMMIT) begin
      if (!({1'b0, alloc_idx} < hwm)) gen_cur = '0;
    end else begin
      if (!({1'b0, cmd.idx} < hwm)) gen_cur = '0;
    end
  end
  assign gen_new = gen_cur + GEN_W'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gtht_pkg::S_IDLE: begin
        if (q_in.valid) begin
          unique case (q_in.head.op)
            gtht_pkg::OP_ALLOC:   state_next = all_full ? gtht_pkg::S_IDLE : gtht_pkg::S_PICK;
            gtht_pkg::OP_RESOLVE: state_next = gtht_pkg::S_PICK;
            gtht_pkg::OP_FREE:    state_next = gtht_pkg::S_PICK;
            gtht_pkg::OP_REPLY:   state_next = gtht_pkg::S_IDLE;
          endcase
        end
      end
      gtht_pkg::S_PICK: begin
        state_next = (cmd.op == gtht_pkg::OP_ALLOC) ? gtht_pkg::S_COMMIT : gtht_pkg::S_IDLE;
      end
      gtht_pkg::S_COMMIT: begin
        state_next = gtht_pkg::S_IDLE;
      end
      default: begin
        state_next = gtht_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    pop        = 1'b0;
    occ_raddr  = sel_row;
    gen_raddr  = q_in.head.idx;
    gen_re     = 1'b0;
    occ_we     = 1'b0;
    occ_wdata  = occ_new;
    commit     = 1'b0;
    free_we    = 1'b0;
    res_fire   = 1'b0;
    res_status = gtht_pkg::ST_NOT_FOUND;
    res_handle = '0;
    res_entry  = '0;
    unique case (state)
      gtht_pkg::S_IDLE: begin
        pop    = q_in.valid;
        gen_re = 1'b1;
        if (q_in.valid) begin
          if (q_in.head.op == gtht_pkg::OP_REPLY) begin
            res_fire   = 1'b1;
            res_status = q_in.head.reply;
          end else if (q_in.head.op == gtht_pkg::OP_ALLOC && all_full) begin
            res_fire   = 1'b1;
            res_status = gtht_pkg::ST_EXHAUSTED;
          end
        end
      end
      gtht_pkg::S_PICK: begin
        gen_raddr = alloc_idx_next;
        gen_re    = 1'b1;
        if (cmd.op == gtht_pkg::OP_RESOLVE) begin
          res_fire = 1'b1;
          if (occ_masked[cmd.idx[BIT_AW-1:0]] && (gen_cur == cmd.gen)) begin
            res_status = gtht_pkg::ST_OK;
            res_entry  = val_q;
          end
        end else if (cmd.op == gtht_pkg::OP_FREE) begin
          res_fire   = 1'b1;
          res_status = gtht_pkg::ST_OK;
          occ_we     = 1'b1;
          free_we    = 1'b1;
          occ_wdata  = occ_masked & ~(ROW_W'(1) << cmd.idx[BIT_AW-1:0]);
        end
      end
      gtht_pkg::S_COMMIT: begin
        commit     = 1'b1;
        occ_we     = 1'b1;
        occ_wdata  = occ_new;
        res_fire   = 1'b1;
        res_status = gtht_pkg::ST_OK;
        res_handle = {gen_new, 32'(alloc_idx)};
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // occupancy rows
  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[row] <= occ_wdata;
    if (state == gtht_pkg::S_IDLE) occ_q <= occ_mem[occ_raddr];
  end

  // generations
  always_ff @(posedge clk) begin
    if (commit) gen_mem[alloc_idx] <= gen_new;
    if (gen_re) gen_q <= gen_mem[gen_raddr];
  end

  // stored values
  always_ff @(posedge clk) begin
    if (commit) val_mem[alloc_idx] <= cmd.value;
    if (state == gtht_pkg::S_IDLE) val_q <= val_mem[q_in.head.idx];
  end

  // item and allocation registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_in.head;
      row <= sel_row;
    end
    if (state == gtht_pkg::S_PICK) begin
      alloc_idx <= alloc_idx_next;
      occ_new   <= occ_new_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gtht_pkg::S_IDLE;
      row_full <= '0;
      hwm      <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_fire;
      if (free_we) row_full[row] <= 1'b0;
      if (commit) begin
        row_full[row] <= &occ_new;
        if ({1'b0, alloc_idx} == hwm) hwm <= hwm + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    status     <= res_status;
    handle_out <= res_handle;
    entry_out  <= res_entry;
  end

endmodule

// ----- rtl/core/generation_tagged_handle_table_top.sv -----
// ----------------------------------------------------------------------------
// generation_tagged_handle_table_top
// Generational handle table: allocate, resolve and free 64-bit handles.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. Each command gives exactly one
// result, shown for one cycle with done high, in command order; the receiver
// cannot hold results off. After the queue, an allocate passes the idle,
// pick and commit states (occupancy row read, generation read, write back),
// a resolve or free idle and pick, a rejected handle or exhausted table idle
// alone; done follows in the next cycle. The unit takes a new command only
// in idle, as the occupancy and generation memories are single-port. No
// clearing pass is needed after reset: a high-water mark stands for all
// slots never allocated.
// ----------------------------------------------------------------------------
module generation_tagged_handle_table_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [gtht_pkg::HANDLE_W-1:0]     handle,
  input  logic [gtht_pkg::VAL_W-1:0]        entry_value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [gtht_pkg::HANDLE_W-1:0]     handle_out,
  output logic [gtht_pkg::VAL_W-1:0]        entry_out
);

  gtht_pkg::queue_head_t q_head;
  logic                  pop;

  gtht_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .handle      (handle),
    .entry_value (entry_value),
    .pop         (pop),
    .q_out       (q_head)
  );

  gtht_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_in       (q_head),
    .pop        (pop),
    .done       (done),
    .status     (status),
    .handle_out (handle_out),
    .entry_out  (entry_out)
  );

endmodule
